[src/suffix_automaton_first_occurrence_core_macros.svh]
// assertion helpers for the suffix automaton core
`ifndef SUFFIX_AUTOMATON_FIRST_OCCURRENCE_CORE_MACROS_SVH
`define SUFFIX_AUTOMATON_FIRST_OCCURRENCE_CORE_MACROS_SVH

// same-cycle implication
`define SAM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/sam_pkg.sv]
package sam_pkg;

   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_APPEND  = 2'd1;
   localparam logic [1:0] CMD_PATTERN = 2'd2;

   localparam int CMD_W  = 2;
   localparam int SYM_IN_W = 5;
   localparam int START_W = 13;
   localparam int PLEN_W = 13;
   localparam logic [PLEN_W-1:0] PLEN_SAT = 13'd8191;

   typedef enum logic [16:0] {
      S_IDLE    = 17'b00000000000000001,
      S_CLEAR   = 17'b00000000000000010,
      S_APP     = 17'b00000000000000100,
      S_ZERO    = 17'b00000000000001000,
      S_L1_RD   = 17'b00000000000010000,
      S_L1_CHK  = 17'b00000000000100000,
      S_V_RD    = 17'b00000000001000000,
      S_V_CHK   = 17'b00000000010000000,
      S_CP_RD   = 17'b00000000100000000,
      S_CP_WR   = 17'b00000001000000000,
      S_L2_RD   = 17'b00000010000000000,
      S_L2_CHK  = 17'b00000100000000000,
      S_FIN_CUR = 17'b00001000000000000,
      S_FIN_V   = 17'b00010000000000000,
      S_P_CHK   = 17'b00100000000000000,
      S_P_OUT   = 17'b01000000000000000,
      S_SPARE   = 17'b10000000000000000
   } state_type;

endpackage

[src/suffix_automaton_first_occurrence_core.sv]
// channel   ports                                           handshake
// request   req_cmd, req_symbol, req_last_of_pattern        start && !busy
// response  rsp_found, rsp_start_position, rsp_text_overflow rsp_valid, one cycle
//
// pattern symbol: S_IDLE after a failure, else S_P_CHK, plus S_P_OUT when last is found
// append: S_APP, S_ZERO per symbol, read and check per state on each suffix link walk,
//   a node read when it stops, a row copy on a clone; one transition ram port sets this
// clear (from idle) and reset both run S_CLEAR, zeroing root row and root node
// rows of new states are zeroed or copied on creation, so no full table clear is needed
// responses cannot be stalled
`include "suffix_automaton_first_occurrence_core_macros.svh"

module suffix_automaton_first_occurrence_core #(
   parameter int MAX_TEXT = 4096,
   parameter int SYMBOL_COUNT = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [sam_pkg::CMD_W-1:0]      req_cmd,
   input  logic [sam_pkg::SYM_IN_W-1:0]   req_symbol,
   input  logic                           req_last_of_pattern,
   output logic                           rsp_valid,
   output logic                           rsp_found,
   output logic [sam_pkg::START_W-1:0]    rsp_start_position,
   output logic                           rsp_text_overflow
);
   import sam_pkg::*;

   localparam int CAP = 2 * MAX_TEXT;
   localparam int STATE_W = $clog2(CAP);
   localparam int POS_W = $clog2(MAX_TEXT + 1);
   localparam int SYM_W = $clog2(SYMBOL_COUNT);
   localparam int TDEPTH = CAP * SYMBOL_COUNT;
   localparam int ADDR_W = $clog2(TDEPTH);
   localparam int NODE_W = 2 * POS_W + STATE_W;
   localparam logic [SYM_W-1:0] IDX_LAST = SYM_W'(SYMBOL_COUNT - 1);

   function automatic logic [ADDR_W-1:0] taddr(input logic [STATE_W-1:0] s,
                                                input logic [SYM_W-1:0] c);
      return ADDR_W'(s) * ADDR_W'(SYMBOL_COUNT) + ADDR_W'(c);
   endfunction

   state_type state_ff, state_in;
   logic [SYM_W-1:0] sym_ff, sym_in, idx_ff, idx_in;
   logic last_ff, last_in;
   logic [STATE_W-1:0] newest_ff, newest_in, walk_ff, walk_in;
   logic [STATE_W-1:0] u_ff, u_in, v_ff, v_in, w_ff, w_in, cur_ff, cur_in;
   logic [STATE_W:0] total_ff, total_in;
   logic [POS_W-1:0] text_len_ff, text_len_in, lenu_ff, lenu_in;
   logic [POS_W-1:0] vlen_ff, vlen_in, vfirst_ff, vfirst_in;
   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic failed_ff, failed_in, ovf_ff, ovf_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_found_ff, rsp_found_in;
   logic [START_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   logic t_we;
   logic [ADDR_W-1:0] t_waddr, t_raddr;
   logic [STATE_W-1:0] t_wdata, t_rdata;
   logic n_we;
   logic [STATE_W-1:0] n_waddr, n_raddr;
   logic [NODE_W-1:0] n_wdata, n_rdata;

   logic [POS_W-1:0] n_len, n_first;
   logic [STATE_W-1:0] n_link;
   logic [SYM_W-1:0] req_sym_idx;
   logic req_sym_ok;
   logic [PLEN_W-1:0] plen_inc;

   sam_ram #(.WIDTH(STATE_W), .DEPTH(TDEPTH)) u_trans_ram (
      .clock(clock), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
      .rd_addr(t_raddr), .rd_data_ff(t_rdata)
   );

   sam_ram #(.WIDTH(NODE_W), .DEPTH(CAP)) u_node_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_waddr), .wr_data(n_wdata),
      .rd_addr(n_raddr), .rd_data_ff(n_rdata)
   );

   // node word: length, link, first end
   assign n_len = n_rdata[NODE_W-1 -: POS_W];
   assign n_link = n_rdata[POS_W +: STATE_W];
   assign n_first = n_rdata[POS_W-1:0];
   assign req_sym_idx = SYM_W'(req_symbol);
   assign req_sym_ok = 32'(req_symbol) < SYMBOL_COUNT;
   assign plen_inc = (plen_ff < PLEN_SAT) ? plen_ff + 1'b1 : plen_ff;

   always_comb begin
      state_in = state_ff;
      sym_in = sym_ff;
      idx_in = idx_ff;
      last_in = last_ff;
      newest_in = newest_ff;
      walk_in = walk_ff;
      u_in = u_ff;
      v_in = v_ff;
      w_in = w_ff;
      cur_in = cur_ff;
      total_in = total_ff;
      text_len_in = text_len_ff;
      lenu_in = lenu_ff;
      vlen_in = vlen_ff;
      vfirst_in = vfirst_ff;
      plen_in = plen_ff;
      failed_in = failed_ff;
      ovf_in = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_ovf_in = rsp_ovf_ff;
      t_we = 1'b0;
      t_waddr = taddr(u_ff, sym_ff);
      t_wdata = '0;
      t_raddr = taddr(walk_ff, req_sym_idx);
      n_we = 1'b0;
      n_waddr = cur_ff;
      n_wdata = '0;
      n_raddr = u_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               sym_in = req_sym_idx;
               last_in = req_last_of_pattern;
               case (req_cmd)
                  CMD_CLEAR: begin
                     idx_in = '0;
                     state_in = S_CLEAR;
                  end
                  CMD_APPEND: begin
                     if (req_sym_ok) state_in = S_APP;
                  end
                  CMD_PATTERN: begin
                     if (failed_ff || !req_sym_ok) begin
                        failed_in = 1'b1;
                        plen_in = plen_inc;
                        if (req_last_of_pattern) begin
                           rsp_valid_in = 1'b1;
                           rsp_found_in = 1'b0;
                           rsp_pos_in = '0;
                           rsp_ovf_in = ovf_ff;
                           walk_in = '0;
                           plen_in = '0;
                           failed_in = 1'b0;
                        end
                     end else begin
                        state_in = S_P_CHK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLEAR: begin
            t_we = 1'b1;
            t_waddr = taddr('0, idx_ff);
            // root node: length zero
            n_we = 1'b1;
            n_waddr = '0;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               newest_in = '0;
               total_in = (STATE_W+1)'(1);
               text_len_in = '0;
               walk_in = '0;
               plen_in = '0;
               failed_in = 1'b0;
               ovf_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_APP: begin
            if (32'(text_len_ff) >= MAX_TEXT || 32'(total_ff) + 2 > CAP) begin
               ovf_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cur_in = total_ff[STATE_W-1:0];
               total_in = total_ff + 1'b1;
               n_we = 1'b1;
               n_waddr = total_ff[STATE_W-1:0];
               n_wdata = {text_len_ff + 1'b1, {STATE_W{1'b0}}, text_len_ff + 1'b1};
               u_in = newest_ff;
               newest_in = total_ff[STATE_W-1:0];
               text_len_in = text_len_ff + 1'b1;
               idx_in = '0;
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            t_we = 1'b1;
            t_waddr = taddr(cur_ff, idx_ff);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) state_in = S_L1_RD;
         end
         S_L1_RD, S_L2_RD: begin
            t_raddr = taddr(u_ff, sym_ff);
            n_raddr = u_ff;
            state_in = (state_ff == S_L1_RD) ? S_L1_CHK : S_L2_CHK;
         end
         S_L1_CHK: begin
            lenu_in = n_len;
            if (t_rdata != '0) begin
               v_in = t_rdata;
               state_in = S_V_RD;
            end else begin
               t_we = 1'b1;
               t_wdata = cur_ff;
               if (u_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  u_in = n_link;
                  state_in = S_L1_RD;
               end
            end
         end
         S_V_RD: begin
            n_raddr = v_ff;
            state_in = S_V_CHK;
         end
         S_V_CHK: begin
            vlen_in = n_len;
            vfirst_in = n_first;
            n_we = 1'b1;
            if ({1'b0, lenu_ff} + 1'b1 == {1'b0, n_len}) begin
               n_wdata = {text_len_ff, v_ff, text_len_ff};
               state_in = S_IDLE;
            end else begin
               // clone v into a fresh state
               w_in = total_ff[STATE_W-1:0];
               total_in = total_ff + 1'b1;
               n_waddr = total_ff[STATE_W-1:0];
               n_wdata = {lenu_ff + 1'b1, n_link, n_first};
               idx_in = '0;
               state_in = S_CP_RD;
            end
         end
         S_CP_RD: begin
            t_raddr = taddr(v_ff, idx_ff);
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            t_we = 1'b1;
            t_waddr = taddr(w_ff, idx_ff);
            t_wdata = t_rdata;
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff == IDX_LAST) ? S_L2_RD : S_CP_RD;
         end
         S_L2_CHK: begin
            if (t_rdata != v_ff) begin
               state_in = S_FIN_CUR;
            end else begin
               t_we = 1'b1;
               t_wdata = w_ff;
               if (u_ff == '0) begin
                  state_in = S_FIN_CUR;
               end else begin
                  u_in = n_link;
                  state_in = S_L2_RD;
               end
            end
         end
         S_FIN_CUR: begin
            n_we = 1'b1;
            n_wdata = {text_len_ff, w_ff, text_len_ff};
            state_in = S_FIN_V;
         end
         S_FIN_V: begin
            n_we = 1'b1;
            n_waddr = v_ff;
            n_wdata = {vlen_ff, w_ff, vfirst_ff};
            state_in = S_IDLE;
         end
         S_P_CHK: begin
            plen_in = plen_inc;
            state_in = S_IDLE;
            if (t_rdata == '0) begin
               failed_in = 1'b1;
               if (last_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_pos_in = '0;
                  rsp_ovf_in = ovf_ff;
                  walk_in = '0;
                  plen_in = '0;
                  failed_in = 1'b0;
               end
            end else begin
               walk_in = t_rdata;
               if (last_ff) begin
                  n_raddr = t_rdata;
                  state_in = S_P_OUT;
               end
            end
         end
         S_P_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b1;
            rsp_pos_in = START_W'(32'(n_first) + 32'd1 - 32'(plen_ff));
            rsp_ovf_in = ovf_ff;
            walk_in = '0;
            plen_in = '0;
            failed_in = 1'b0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff <= '0;
         newest_ff <= '0;
         total_ff <= (STATE_W+1)'(1);
         text_len_ff <= '0;
         walk_ff <= '0;
         plen_ff <= '0;
         failed_ff <= 1'b0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         newest_ff <= newest_in;
         total_ff <= total_in;
         text_len_ff <= text_len_in;
         walk_ff <= walk_in;
         plen_ff <= plen_in;
         failed_ff <= failed_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff <= sym_in;
      last_ff <= last_in;
      u_ff <= u_in;
      v_ff <= v_in;
      w_ff <= w_in;
      cur_ff <= cur_in;
      lenu_ff <= lenu_in;
      vlen_ff <= vlen_in;
      vfirst_ff <= vfirst_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_start_position = rsp_pos_ff;
   assign rsp_text_overflow = rsp_ovf_ff;

   `SAM_ASSERT_NOW(a_miss_pos_zero, clock, reset, rsp_valid && !rsp_found, rsp_start_position == '0)
   `SAM_ASSERT_NEXT(a_append_busy, clock, reset, start && !busy && req_cmd == CMD_APPEND && req_symbol == '0, busy)
   `SAM_ASSERT_NOW(a_total_cap, clock, reset, 1'b1, 32'(total_ff) <= CAP)
   `SAM_ASSERT_NOW(a_walk_idle_rsp, clock, reset, rsp_valid, !rsp_found || walk_ff == '0)

endmodule

[src/sam_ram.sv]
module sam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule
